>>> hdl/acl_pkg.sv
package acl_pkg;

   localparam int ACL_DEPTH_DEFAULT = 64;
   localparam int GROUP_BITS        = 64;
   localparam int GROUP_IDX_W       = $clog2(GROUP_BITS);
   localparam int CMD_FIFO_DEPTH    = 2;

   localparam logic [63:0] ADMIN_MASK_RESET = 64'd1;

   localparam logic [1:0] FUNC_BEGIN  = 2'd0;
   localparam logic [1:0] FUNC_APPEND = 2'd1;
   localparam logic [1:0] FUNC_CHECK  = 2'd2;

   typedef enum logic [1:0] {
      OP_BEGIN,
      OP_APPEND,
      OP_CHECK
   } op_type;

   typedef enum logic [2:0] {
      KIND_OWNER    = 3'd0,
      KIND_USER     = 3'd1,
      KIND_GROUP    = 3'd2,
      KIND_EVERYONE = 3'd3,
      KIND_UNKNOWN  = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_GRANTED = 2'd0,
      STATUS_DENIED  = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] owner_id;
      logic        descriptor_present;
      logic        acl_present;
      logic [2:0]  principal_kind;
      logic [31:0] trustee_id;
      logic [31:0] entry_permissions;
      logic [31:0] token_uid;
      logic [31:0] token_gid;
      logic [63:0] token_groups;
      logic [31:0] desired;
      logic        bypass;
      logic        invalid;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] id;
      logic [31:0] perms;
   } entry_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] granted;
      logic        audit_denied;
      logic [31:0] audit_owner;
      logic [31:0] audit_uid;
      logic [31:0] audit_gid;
   } rsp_type;

endpackage

>>> hdl/acl_front.sv
module acl_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [1:0]            req_func,
   input  logic [31:0]           req_owner_id,
   input  logic                  req_descriptor_present,
   input  logic                  req_acl_present,
   input  logic [2:0]            req_principal_kind,
   input  logic [31:0]           req_trustee_id,
   input  logic [31:0]           req_entry_permissions,
   input  logic [31:0]           req_token_uid,
   input  logic [31:0]           req_token_gid,
   input  logic [63:0]           req_token_groups,
   input  logic [63:0]           req_token_capabilities,
   input  logic [31:0]           req_desired,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [63:0]           csr_wdata,
   input  acl_pkg::fifo_stat_type fifo_stat,
   output logic                  cmd_push,
   output acl_pkg::cmd_type      cmd_data
);
   import acl_pkg::*;

   logic [63:0] admin_mask_ff;
   logic [63:0] admin_mask_in;
   logic        func_known;

   assign csr_ready = 1'b1;
   assign req_full  = fifo_stat.full;

   always_comb begin
      admin_mask_in = admin_mask_ff;
      if (csr_valid && csr_ready) begin
         admin_mask_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         admin_mask_ff <= ADMIN_MASK_RESET;
      end else begin
         admin_mask_ff <= admin_mask_in;
      end
   end

   // classify; the unused function code is taken and dropped here
   always_comb begin
      func_known                  = 1'b1;
      cmd_data.op                 = OP_CHECK;
      case (req_func)
         FUNC_BEGIN:  cmd_data.op = OP_BEGIN;
         FUNC_APPEND: cmd_data.op = OP_APPEND;
         FUNC_CHECK:  cmd_data.op = OP_CHECK;
         default:     func_known  = 1'b0;
      endcase
      cmd_data.owner_id           = req_owner_id;
      cmd_data.descriptor_present = req_descriptor_present;
      cmd_data.acl_present        = req_acl_present;
      cmd_data.principal_kind     = req_principal_kind;
      cmd_data.trustee_id         = req_trustee_id;
      cmd_data.entry_permissions  = req_entry_permissions;
      cmd_data.token_uid          = req_token_uid;
      cmd_data.token_gid          = req_token_gid;
      cmd_data.token_groups       = req_token_groups;
      cmd_data.desired            = req_desired;
      cmd_data.bypass             = |(req_token_capabilities & admin_mask_ff);
      cmd_data.invalid            = (req_desired == 32'd0);
      cmd_push                    = req_push && !fifo_stat.full && func_known;
   end

endmodule

>>> hdl/acl_cmd_fifo.sv
module acl_cmd_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  acl_pkg::cmd_type       push_data,
   input  logic                   pop,
   output acl_pkg::cmd_type       pop_data,
   output acl_pkg::fifo_stat_type stat
);
   import acl_pkg::*;

   localparam int DEPTH = CMD_FIFO_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push && !stat.full;
      do_pop    = pop && !stat.empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/acl_back.sv
module acl_back #(
   parameter int ACL_DEPTH = acl_pkg::ACL_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  acl_pkg::fifo_stat_type fifo_stat,
   output logic                   cmd_pop,
   input  acl_pkg::cmd_type       cmd_data,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output acl_pkg::rsp_type       rsp_data
);
   import acl_pkg::*;

   localparam int IDX_W = (ACL_DEPTH > 1) ? $clog2(ACL_DEPTH) : 1;
   localparam int CNT_W = $clog2(ACL_DEPTH + 1);

   entry_type         table_mem [ACL_DEPTH];

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              overflow_ff, overflow_in;
   logic [31:0]       owner_ff, owner_in;
   logic              has_desc_ff, has_desc_in;
   logic              has_acl_ff, has_acl_in;
   cmd_type           cur_ff, cur_in;
   logic [31:0]       allowed_ff, allowed_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              rd_vld_ff;
   entry_type         rd_data_ff;
   rsp_type           out_ff, out_in;
   logic              out_vld_ff, out_vld_in;

   logic              mem_we;
   entry_type         mem_wdata;
   logic              issue;
   logic              hit;
   logic              out_load;
   logic [31:0]       got;
   rsp_type           fin;

   assign rsp_empty = !out_vld_ff;
   assign rsp_data  = out_ff;

   // match test on the entry read out last cycle
   always_comb begin
      case (rd_data_ff.kind)
         KIND_OWNER:    hit = (cur_ff.token_uid == owner_ff);
         KIND_USER:     hit = (cur_ff.token_uid == rd_data_ff.id);
         KIND_GROUP:    hit = (rd_data_ff.id[31:GROUP_IDX_W] == '0) &&
                              cur_ff.token_groups[rd_data_ff.id[GROUP_IDX_W-1:0]];
         KIND_EVERYONE: hit = 1'b1;
         default:       hit = 1'b0;
      endcase
   end

   always_comb begin
      got              = allowed_ff & cur_ff.desired;
      fin              = '0;
      fin.status       = STATUS_GRANTED;
      fin.granted      = got;
      if (cur_ff.invalid) begin
         fin.status    = STATUS_INVALID;
         fin.granted   = '0;
      end else if (got != cur_ff.desired) begin
         fin.status       = STATUS_DENIED;
         fin.audit_denied = 1'b1;
         fin.audit_owner  = has_desc_ff ? owner_ff : '0;
         fin.audit_uid    = cur_ff.token_uid;
         fin.audit_gid    = cur_ff.token_gid;
      end
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      owner_in    = owner_ff;
      has_desc_in = has_desc_ff;
      has_acl_in  = has_acl_ff;
      cur_in      = cur_ff;
      allowed_in  = allowed_ff;
      rd_idx_in   = rd_idx_ff;
      cmd_pop     = 1'b0;
      mem_we      = 1'b0;
      mem_wdata.kind  = cmd_data.principal_kind;
      mem_wdata.id    = cmd_data.trustee_id;
      mem_wdata.perms = cmd_data.entry_permissions;
      issue       = 1'b0;
      out_load    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!fifo_stat.empty) begin
               cmd_pop = 1'b1;
               case (cmd_data.op)
                  OP_BEGIN: begin
                     owner_in    = cmd_data.owner_id;
                     has_desc_in = cmd_data.descriptor_present;
                     has_acl_in  = cmd_data.acl_present;
                     count_in    = '0;
                     overflow_in = 1'b0;
                  end
                  OP_APPEND: begin
                     if (count_ff < CNT_W'(ACL_DEPTH)) begin
                        mem_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
                  OP_CHECK: begin
                     cur_in     = cmd_data;
                     rd_idx_in  = '0;
                     allowed_in = '0;
                     state_in   = ST_FINISH;
                     if (cmd_data.invalid) begin
                        allowed_in = '0;
                     end else if (cmd_data.bypass || !has_desc_ff) begin
                        allowed_in = cmd_data.desired;
                     end else if (!has_acl_ff) begin
                        allowed_in = (cmd_data.token_uid == owner_ff) ?
                                     cmd_data.desired : '0;
                     end else if (!overflow_ff) begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            issue = (rd_idx_ff < count_ff);
            if (issue) begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            if (rd_vld_ff && hit) begin
               allowed_in = allowed_ff | rd_data_ff.perms;
            end
            if (!issue && !rd_vld_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!out_vld_ff || rsp_pop) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_in     = out_ff;
      out_vld_in = out_vld_ff;
      if (out_load) begin
         out_in     = fin;
         out_vld_in = 1'b1;
      end else if (rsp_pop && out_vld_ff) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         owner_ff    <= '0;
         has_desc_ff <= 1'b0;
         has_acl_ff  <= 1'b0;
         rd_idx_ff   <= '0;
         rd_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         owner_ff    <= owner_in;
         has_desc_ff <= has_desc_in;
         has_acl_ff  <= has_acl_in;
         rd_idx_ff   <= rd_idx_in;
         rd_vld_ff   <= issue;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      allowed_ff <= allowed_in;
      out_ff     <= out_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[count_ff[IDX_W-1:0]] <= mem_wdata;
      end
      if (issue) begin
         rd_data_ff <= table_mem[rd_idx_ff[IDX_W-1:0]];
      end
   end

endmodule

>>> hdl/acl_access_check_engine.sv
// Begin and append items are handled on the execute side as they are popped. A check walks
// the ACL one entry per cycle through a registered read port, and the next item is
// not taken from the queue until the check's result has been loaded; checks settled
// without the table skip the walk.
// Synchronous reset empties the queues, clears the descriptor and sets the
// admin mask to 1; table contents are left as they are.
module acl_access_check_engine #(
   parameter int ACL_DEPTH = acl_pkg::ACL_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_owner_id,
   input  logic        req_descriptor_present,
   input  logic        req_acl_present,
   input  logic [2:0]  req_principal_kind,
   input  logic [31:0] req_trustee_id,
   input  logic [31:0] req_entry_permissions,
   input  logic [31:0] req_token_uid,
   input  logic [31:0] req_token_gid,
   input  logic [63:0] req_token_groups,
   input  logic [63:0] req_token_capabilities,
   input  logic [31:0] req_desired,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_granted,
   output logic        rsp_audit_denied,
   output logic [31:0] rsp_audit_owner,
   output logic [31:0] rsp_audit_uid,
   output logic [31:0] rsp_audit_gid,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_wdata
);
   import acl_pkg::*;

   fifo_stat_type fifo_stat;
   logic          cmd_push;
   cmd_type       cmd_in_data;
   logic          cmd_pop;
   cmd_type       cmd_out_data;
   rsp_type       rsp_data;

   acl_front u_front (
      .clock                  (clock),
      .reset                  (reset),
      .req_push               (req_push),
      .req_full               (req_full),
      .req_func               (req_func),
      .req_owner_id           (req_owner_id),
      .req_descriptor_present (req_descriptor_present),
      .req_acl_present        (req_acl_present),
      .req_principal_kind     (req_principal_kind),
      .req_trustee_id         (req_trustee_id),
      .req_entry_permissions  (req_entry_permissions),
      .req_token_uid          (req_token_uid),
      .req_token_gid          (req_token_gid),
      .req_token_groups       (req_token_groups),
      .req_token_capabilities (req_token_capabilities),
      .req_desired            (req_desired),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_wdata              (csr_wdata),
      .fifo_stat              (fifo_stat),
      .cmd_push               (cmd_push),
      .cmd_data               (cmd_in_data)
   );

   acl_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_data),
      .stat      (fifo_stat)
   );

   acl_back #(
      .ACL_DEPTH (ACL_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .fifo_stat (fifo_stat),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_out_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   assign rsp_status       = rsp_data.status;
   assign rsp_granted      = rsp_data.granted;
   assign rsp_audit_denied = rsp_data.audit_denied;
   assign rsp_audit_owner  = rsp_data.audit_owner;
   assign rsp_audit_uid    = rsp_data.audit_uid;
   assign rsp_audit_gid    = rsp_data.audit_gid;

   a_fifo_stat_sane: assert property (@(posedge clock) disable iff (reset)
      !(fifo_stat.full && fifo_stat.empty))
      else $error("command queue reports full and empty together");

   a_invalid_quiet: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == STATUS_INVALID) |->
      (rsp_granted == 32'd0 && !rsp_audit_denied))
      else $error("invalid request carries grant or audit");

   a_audit_on_deny: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_audit_denied == (rsp_status == STATUS_DENIED)))
      else $error("audit flag disagrees with status");

   a_grant_nonzero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == STATUS_GRANTED) |-> (rsp_granted != 32'd0))
      else $error("granted status with no bits granted");

endmodule

>>> sim/acl_access_check_engine_tb.sv
`timescale 1ns / 100ps

module acl_access_check_engine_tb;
   import acl_pkg::*;

   localparam int         ACL_DEPTH    = ACL_DEPTH_DEFAULT;
   localparam int         N_ITEMS      = 1850;
   localparam int         N_PHASES     = 5;
   localparam int         CYCLE_CAP    = 1000000;
   localparam int         SETTLE       = 16;
   localparam int         REPORT_LIMIT = 10;
   localparam logic [1:0] FUNC_SPARE   = 2'd3;
   localparam logic [2:0] KIND_TOP     = 3'd7;

   typedef struct {
      logic [1:0]  func;
      logic [31:0] owner_id;
      logic        descriptor_present;
      logic        acl_present;
      logic [2:0]  principal_kind;
      logic [31:0] trustee_id;
      logic [31:0] entry_permissions;
      logic [31:0] token_uid;
      logic [31:0] token_gid;
      logic [63:0] token_groups;
      logic [63:0] token_capabilities;
      logic [31:0] desired;
   } acl_req;

   // Shadow of the descriptor and ACL, plus the decisions still owed by the block
   class acl_decision_board;
      logic [63:0] admin_mask;
      logic [2:0]  ent_kind  [ACL_DEPTH];
      logic [31:0] ent_id    [ACL_DEPTH];
      logic [31:0] ent_perms [ACL_DEPTH];
      int unsigned ent_count;
      bit          ent_overflow;
      logic [31:0] owner;
      bit          desc_valid;
      bit          acl_valid;
      rsp_type     owed_decisions[$];
      int unsigned errors;

      function new();
         admin_mask   = ADMIN_MASK_RESET;
         ent_count    = 0;
         ent_overflow = 1'b0;
         owner        = '0;
         desc_valid   = 1'b0;
         acl_valid    = 1'b0;
         errors       = 0;
      endfunction

      function bit entry_matches(int idx, logic [31:0] uid, logic [63:0] groups);
         case (ent_kind[idx])
            KIND_OWNER:    return uid == owner;
            KIND_USER:     return uid == ent_id[idx];
            KIND_GROUP:    return ent_id[idx] < GROUP_BITS &&
                                  groups[ent_id[idx][GROUP_IDX_W-1:0]];
            KIND_EVERYONE: return 1'b1;
            default:       return 1'b0;
         endcase
      endfunction

      function void predict_access(acl_req r);
         logic [31:0] allowed;
         logic [31:0] got;
         rsp_type     d;
         case (r.func)
            FUNC_BEGIN: begin
               owner        = r.owner_id;
               desc_valid   = r.descriptor_present;
               acl_valid    = r.acl_present;
               ent_count    = 0;
               ent_overflow = 1'b0;
            end
            FUNC_APPEND: begin
               if (ent_count < ACL_DEPTH) begin
                  ent_kind[ent_count]  = r.principal_kind;
                  ent_id[ent_count]    = r.trustee_id;
                  ent_perms[ent_count] = r.entry_permissions;
                  ent_count++;
               end else begin
                  ent_overflow = 1'b1;
               end
            end
            FUNC_CHECK: begin
               d       = '0;
               allowed = '0;
               if (r.desired == '0) begin
                  d.status = STATUS_INVALID;
               end else begin
                  if (!desc_valid || (r.token_capabilities & admin_mask) != '0) begin
                     allowed = r.desired;
                  end else if (!acl_valid) begin
                     if (r.token_uid == owner)
                        allowed = r.desired;
                  end else if (!ent_overflow) begin
                     for (int i = 0; i < ent_count; i++)
                        if (entry_matches(i, r.token_uid, r.token_groups))
                           allowed |= ent_perms[i];
                  end
                  got       = allowed & r.desired;
                  d.granted = got;
                  d.status  = STATUS_GRANTED;
                  if (got != r.desired) begin
                     d.status       = STATUS_DENIED;
                     d.audit_denied = 1'b1;
                     d.audit_owner  = desc_valid ? owner : '0;
                     d.audit_uid    = r.token_uid;
                     d.audit_gid    = r.token_gid;
                  end
               end
               owed_decisions.push_back(d);
            end
            default: ;
         endcase
      endfunction

      function void check_decision(rsp_type got);
         rsp_type want;
         if (owed_decisions.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("unexpected result: status %0d granted %h audit %0b",
                        got.status, got.granted, got.audit_denied);
            return;
         end
         want = owed_decisions.pop_front();
         if (got.status !== want.status || got.granted !== want.granted ||
             got.audit_denied !== want.audit_denied ||
             got.audit_owner !== want.audit_owner ||
             got.audit_uid !== want.audit_uid || got.audit_gid !== want.audit_gid) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("mismatch: expected status %0d granted %h audit %0b %h %h %h",
                        want.status, want.granted, want.audit_denied,
                        want.audit_owner, want.audit_uid, want.audit_gid);
               $display("          actual   status %0d granted %h audit %0b %h %h %h",
                        got.status, got.granted, got.audit_denied,
                        got.audit_owner, got.audit_uid, got.audit_gid);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [1:0]  req_func;
   logic [31:0] req_owner_id;
   logic        req_descriptor_present;
   logic        req_acl_present;
   logic [2:0]  req_principal_kind;
   logic [31:0] req_trustee_id;
   logic [31:0] req_entry_permissions;
   logic [31:0] req_token_uid;
   logic [31:0] req_token_gid;
   logic [63:0] req_token_groups;
   logic [63:0] req_token_capabilities;
   logic [31:0] req_desired;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_granted;
   logic        rsp_audit_denied;
   logic [31:0] rsp_audit_owner;
   logic [31:0] rsp_audit_uid;
   logic [31:0] rsp_audit_gid;
   logic        csr_valid;
   logic        csr_ready;
   logic [63:0] csr_wdata;

   acl_decision_board board;
   int          cycles = 0;
   int          items_sent = 0;
   bit          calm = 1'b0;
   logic [31:0] uid_pool [4];

   acl_access_check_engine #(.ACL_DEPTH(ACL_DEPTH)) dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycles <= cycles + 1;

   initial begin
      wait (cycles >= CYCLE_CAP);
      $display("DONE: errors detected");
      $finish;
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_uid();
      if ($urandom_range(0, 99) < 85)
         return uid_pool[$urandom_range(0, 3)];
      return rand_word();
   endfunction

   function automatic acl_req rand_req();
      acl_req r;
      r.func               = 2'($urandom_range(0, 2));
      r.owner_id           = rand_word();
      r.descriptor_present = 1'($urandom_range(0, 1));
      r.acl_present        = 1'($urandom_range(0, 1));
      r.principal_kind     = 3'($urandom_range(0, 7));
      r.trustee_id         = rand_word();
      r.entry_permissions  = rand_word();
      r.token_uid          = rand_word();
      r.token_gid          = rand_word();
      r.token_groups       = {$urandom, $urandom};
      r.token_capabilities = {$urandom, $urandom};
      r.desired            = rand_word();
      return r;
   endfunction

   function automatic acl_req begin_req(logic [31:0] owner, logic desc, logic acl);
      acl_req r;
      r                    = rand_req();
      r.func               = FUNC_BEGIN;
      r.owner_id           = owner;
      r.descriptor_present = desc;
      r.acl_present        = acl;
      return r;
   endfunction

   function automatic acl_req append_req(logic [2:0] kind, logic [31:0] id,
                                         logic [31:0] perms);
      acl_req r;
      r                   = rand_req();
      r.func              = FUNC_APPEND;
      r.principal_kind    = kind;
      r.trustee_id        = id;
      r.entry_permissions = perms;
      return r;
   endfunction

   function automatic acl_req check_req(logic [31:0] uid, logic [31:0] gid,
                                        logic [63:0] groups, logic [63:0] caps,
                                        logic [31:0] want);
      acl_req r;
      r                    = rand_req();
      r.func               = FUNC_CHECK;
      r.token_uid          = uid;
      r.token_gid          = gid;
      r.token_groups       = groups;
      r.token_capabilities = caps;
      r.desired            = want;
      return r;
   endfunction

   task automatic send(acl_req r);
      while (!calm && $urandom_range(0, 99) < 9) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push               <= 1'b1;
      req_func               <= r.func;
      req_owner_id           <= r.owner_id;
      req_descriptor_present <= r.descriptor_present;
      req_acl_present        <= r.acl_present;
      req_principal_kind     <= r.principal_kind;
      req_trustee_id         <= r.trustee_id;
      req_entry_permissions  <= r.entry_permissions;
      req_token_uid          <= r.token_uid;
      req_token_gid          <= r.token_gid;
      req_token_groups       <= r.token_groups;
      req_token_capabilities <= r.token_capabilities;
      req_desired            <= r.desired;
      do @(posedge clock); while (req_full);
      board.predict_access(r);
      if (r.func != FUNC_SPARE)
         items_sent++;
      calm = items_sent >= 700 && items_sent < 1000;
   endtask

   // begin and append transfers give no result, so allow them to drain too
   task automatic settle();
      req_push <= 1'b0;
      while (board.owed_decisions.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_admin_mask(logic [63:0] v);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.admin_mask = v;
   endtask

   task automatic run_sequence();
      int          r;
      int          n_app;
      logic [2:0]  kind;
      logic [31:0] id;
      logic [31:0] perms;
      logic [63:0] groups;
      logic [63:0] caps;
      logic [31:0] want;
      acl_req      q;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         // noise: loose items in any order
         repeat ($urandom_range(1, 5)) begin
            q = rand_req();
            if ($urandom_range(0, 19) == 0)
               q.func = FUNC_SPARE;
            send(q);
         end
         return;
      end
      foreach (uid_pool[i])
         uid_pool[i] = rand_word();
      // a few sequences skip the begin and append onto the old list
      if (r >= 12)
         send(begin_req(uid_pool[0], $urandom_range(0, 9) != 0, $urandom_range(0, 7) != 0));
      r = $urandom_range(0, 99);
      if (r < 70)
         n_app = $urandom_range(0, 6);
      else if (r < 92)
         n_app = $urandom_range(7, 20);
      else
         n_app = $urandom_range(ACL_DEPTH - 4, ACL_DEPTH + 4);
      repeat (n_app) begin
         case ($urandom_range(0, 19))
            0, 1, 2:        kind = KIND_OWNER;
            8, 9, 10, 11:   kind = KIND_GROUP;
            12, 13, 14:     kind = KIND_EVERYONE;
            15, 16:         kind = KIND_UNKNOWN;
            17:             kind = 3'($urandom_range(KIND_UNKNOWN + 1, KIND_TOP));
            default:        kind = KIND_USER;
         endcase
         if (kind == KIND_USER)
            id = pick_uid();
         else if (kind == KIND_GROUP && $urandom_range(0, 99) < 85)
            id = $urandom_range(0, GROUP_BITS - 1);
         else
            id = rand_word();
         perms = $urandom_range(0, 99) < 75 ? 32'($urandom_range(0, 255)) : rand_word();
         send(append_req(kind, id, perms));
      end
      repeat ($urandom_range(1, 4)) begin
         case ($urandom_range(0, 9))
            0:       groups = '0;
            1:       groups = '1;
            default: groups = {$urandom, $urandom};
         endcase
         case ($urandom_range(0, 19))
            0, 1, 2:    caps = {$urandom, $urandom};
            3, 4, 5:    caps = 64'd1 << $urandom_range(0, 63);
            6, 7:       caps = '1;
            default:    caps = '0;
         endcase
         case ($urandom_range(0, 19))
            0, 1:       want = '0;
            2, 3, 4:    want = rand_word();
            5:          want = '1;
            default:    want = $urandom_range(1, 15);
         endcase
         send(check_req(pick_uid(), rand_word(), groups, caps, want));
      end
   endtask

   initial begin
      rsp_type seen;
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            seen.status       = status_type'(rsp_status);
            seen.granted      = rsp_granted;
            seen.audit_denied = rsp_audit_denied;
            seen.audit_owner  = rsp_audit_owner;
            seen.audit_uid    = rsp_audit_uid;
            seen.audit_gid    = rsp_audit_gid;
            board.check_decision(seen);
         end
         rsp_pop <= calm || $urandom_range(0, 99) >= 9;
      end
   end

   initial begin
      logic [63:0] masks [N_PHASES];
      board                  = new;
      reset                  = 1'b1;
      req_push               = 1'b0;
      req_func               = FUNC_BEGIN;
      req_owner_id           = '0;
      req_descriptor_present = 1'b0;
      req_acl_present        = 1'b0;
      req_principal_kind     = KIND_OWNER;
      req_trustee_id         = '0;
      req_entry_permissions  = '0;
      req_token_uid          = '0;
      req_token_gid          = '0;
      req_token_groups       = '0;
      req_token_capabilities = '0;
      req_desired            = '0;
      csr_valid              = 1'b0;
      csr_wdata              = '0;
      masks = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                {$urandom, $urandom}, ADMIN_MASK_RESET};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // no descriptor after reset: all granted; zero desired is invalid
      send(check_req('0, '1, '0, '0, '1));
      send(check_req('1, '0, '1, '1, '0));
      // descriptor without ACL: owner only, admin bit bypasses
      send(begin_req('1, 1'b1, 1'b0));
      send(check_req('1, 32'h1, '0, '0, '1));
      send(check_req('0, '1, '1, '0, 32'h1));
      send(check_req('0, 32'h5, '0, 64'h1, '1));
      // one entry of each kind, but two of group (one with an id out of range) and one of kind 7
      send(begin_req('0, 1'b1, 1'b1));
      send(append_req(KIND_OWNER, '1, 32'h1));
      send(append_req(KIND_USER, '1, 32'h2));
      send(append_req(KIND_GROUP, 32'(GROUP_BITS - 1), 32'h4));
      send(append_req(KIND_GROUP, 32'(GROUP_BITS), 32'h8));
      send(append_req(KIND_EVERYONE, '0, 32'h10));
      send(append_req(KIND_UNKNOWN, '0, '1));
      send(append_req(KIND_TOP, '1, '1));
      send(check_req('0, '0, 64'h8000_0000_0000_0000, '0, '1));
      send(check_req('1, '0, '1, 64'hFFFF_FFFF_FFFF_FFFE, 32'h16));
      send(check_req('0, '0, '1, '0, 32'h8));
      send(rand_req());
      // empty ACL grants nothing
      send(begin_req(32'h5, 1'b1, 1'b1));
      send(check_req(32'h5, 32'h7, '1, '0, 32'h1));
      // entries stored without a descriptor are unused
      send(begin_req(32'h9, 1'b0, 1'b1));
      send(append_req(KIND_USER, 32'h1, '0));
      send(check_req(32'h1, 32'h2, '0, '0, 32'hFFFF_0000));
      settle();

      for (int p = 0; p < N_PHASES; p++) begin
         write_admin_mask(masks[p]);
         while (items_sent < (p + 1) * N_ITEMS / N_PHASES)
            run_sequence();
         settle();
      end

      if (board.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
